/* rtl/lmlt_pkg.sv */
`default_nettype none

package lmlt_pkg;

  localparam int unsigned LINE_W = 8;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned SUM_W  = CNT_W + 1;
  localparam int unsigned CYC_W  = 8;
  localparam int unsigned VAL_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_EN    = 2'd1,
    OP_LINE_RST  = 2'd2,
    OP_CMP_WRITE = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HBLANK_IRQ_EN   = 2'd0,
    CFG_VBLANK_STAT_EN  = 2'd1,
    CFG_OAM_IRQ_EN      = 2'd2,
    CFG_COINC_IRQ_EN    = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_HBLANK = 4'b0001,
    ST_VBLANK = 4'b0010,
    ST_OAM    = 4'b0100,
    ST_VRAM   = 4'b1000
  } state_e;

  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_VRAM   = 2'd3;

  localparam logic [SUM_W-1:0] OAM_CYCLES    = 10'd20;
  localparam logic [SUM_W-1:0] VRAM_CYCLES   = 10'd43;
  localparam logic [SUM_W-1:0] HBLANK_CYCLES = 10'd51;
  localparam logic [SUM_W-1:0] LINE_CYCLES   = 10'd114;
  localparam logic [SUM_W-1:0] COUNT_MAX     = 10'd511;

  localparam logic [LINE_W-1:0] VBLANK_FIRST_LINE = 8'd144;
  localparam logic [LINE_W-1:0] LAST_LINE         = 8'd153;

  typedef struct packed {
    logic hblank;
    logic vblank;
    logic oam;
    logic coinc;
  } irq_en_t;

  function automatic logic [1:0] mode_code(state_e st);
    logic [1:0] code;
    unique case (st)
      ST_HBLANK: code = MODE_HBLANK;
      ST_VBLANK: code = MODE_VBLANK;
      ST_OAM:    code = MODE_OAM;
      ST_VRAM:   code = MODE_VRAM;
      default:   code = MODE_OAM;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* rtl/lmlt_if.sv */
`default_nettype none

interface lmlt_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      mode;
  logic [lmlt_pkg::CYC_W-1:0]      cycles;
  logic [lmlt_pkg::VAL_W-1:0]      value;

  modport source (output valid, output mode, output cycles, output value, input ready);
  modport sink   (input valid, input mode, input cycles, input value, output ready);
endinterface

interface lmlt_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      lcd_mode;
  logic [lmlt_pkg::LINE_W-1:0]     line;
  logic                            coincidence;
  logic                            vblank_irq;
  logic                            stat_irq;
  logic                            render_line;
  logic                            frame_done;

  modport source (output valid, output lcd_mode, output line, output coincidence,
                  output vblank_irq, output stat_irq, output render_line,
                  output frame_done, input ready);
  modport sink   (input valid, input lcd_mode, input line, input coincidence,
                  input vblank_irq, input stat_irq, input render_line,
                  input frame_done, output ready);
endinterface

interface lmlt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lmlt_pkg::CFG_IDX_W-1:0]    index;
  logic [lmlt_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/lcd_mode_line_timer.sv */
`default_nettype none

// channel  dir  handshake        payload
// in_i     in   valid / ready    mode, cycles, value
// out_o    out  valid / ready    lcd_mode, line, coincidence, vblank_irq,
//                                stat_irq, render_line, frame_done
// cfg_i    in   valid / ready    index, data (bit 0 used)
//
// one transaction per cycle sustained while out_o.ready stays high
// the item sits in an input register, the add, compare and transition logic
// feeds the result register and the timing state in the same cycle
// a stalled result holds the timing state; the input register takes one more
// transaction while empty, then in_i.ready stays low until the result is taken
// rst_ni clears the handshake state, the timing state and the config bits

module lcd_mode_line_timer (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  lmlt_in_if.sink        in_i,
  lmlt_out_if.source     out_o,
  lmlt_cfg_if.sink       cfg_i
);

  localparam int unsigned LW = lmlt_pkg::LINE_W;
  localparam int unsigned CW = lmlt_pkg::CNT_W;
  localparam int unsigned SW = lmlt_pkg::SUM_W;

  logic                  in_valid_q;
  logic [1:0]            in_mode_q;
  logic [lmlt_pkg::CYC_W-1:0] in_cycles_q;
  logic [lmlt_pkg::VAL_W-1:0] in_value_q;

  logic                  out_valid_q;
  logic [1:0]            out_mode_q;
  logic [LW-1:0]         out_line_q;
  logic                  out_coinc_q;
  logic                  out_vbl_q;
  logic                  out_stat_q;
  logic                  out_rnd_q;
  logic                  out_frm_q;

  lmlt_pkg::irq_en_t     irq_en_q;
  logic                  en_q, en_d;
  lmlt_pkg::state_e      st_q, st_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [LW-1:0]         line_q, line_d;
  logic [LW-1:0]         cmp_q, cmp_d;

  logic [SW-1:0]         sum;
  logic [LW-1:0]         line_inc;
  logic                  line_set;
  logic                  mode_irq;
  logic                  vbl_pulse;
  logic                  rnd_pulse;
  logic                  frm_pulse;
  logic                  stat_pulse;
  logic                  advance;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  assign line_inc = (line_q == lmlt_pkg::LAST_LINE) ? '0 : line_q + LW'(1);

  always_comb begin
    en_d      = en_q;
    st_d      = st_q;
    cnt_d     = cnt_q;
    line_d    = line_q;
    cmp_d     = cmp_q;
    sum       = {1'b0, cnt_q} + SW'(in_cycles_q);
    line_set  = 1'b0;
    mode_irq  = 1'b0;
    vbl_pulse = 1'b0;
    rnd_pulse = 1'b0;
    frm_pulse = 1'b0;
    unique case (lmlt_pkg::op_e'(in_mode_q))
      lmlt_pkg::OP_TICK: begin
        if (en_q) begin
          unique case (st_q)
            lmlt_pkg::ST_OAM: begin
              if (sum >= lmlt_pkg::OAM_CYCLES) begin
                sum  = sum - lmlt_pkg::OAM_CYCLES;
                st_d = lmlt_pkg::ST_VRAM;
              end
            end
            lmlt_pkg::ST_VRAM: begin
              if (sum >= lmlt_pkg::VRAM_CYCLES) begin
                sum       = sum - lmlt_pkg::VRAM_CYCLES;
                st_d      = lmlt_pkg::ST_HBLANK;
                mode_irq  = irq_en_q.hblank;
                rnd_pulse = 1'b1;
              end
            end
            lmlt_pkg::ST_HBLANK: begin
              if (sum >= lmlt_pkg::HBLANK_CYCLES) begin
                sum      = sum - lmlt_pkg::HBLANK_CYCLES;
                line_d   = line_inc;
                line_set = 1'b1;
                if (line_inc == lmlt_pkg::VBLANK_FIRST_LINE) begin
                  st_d      = lmlt_pkg::ST_VBLANK;
                  mode_irq  = irq_en_q.vblank;
                  vbl_pulse = 1'b1;
                  frm_pulse = 1'b1;
                end else begin
                  st_d     = lmlt_pkg::ST_OAM;
                  mode_irq = irq_en_q.oam;
                end
              end
            end
            lmlt_pkg::ST_VBLANK: begin
              if (sum >= lmlt_pkg::LINE_CYCLES) begin
                sum      = sum - lmlt_pkg::LINE_CYCLES;
                line_d   = line_inc;
                line_set = 1'b1;
                if (line_inc == '0) begin
                  st_d     = lmlt_pkg::ST_OAM;
                  mode_irq = irq_en_q.oam;
                end else begin
                  st_d     = lmlt_pkg::ST_VBLANK;
                  mode_irq = irq_en_q.vblank;
                end
              end
            end
            default: ;
          endcase
          cnt_d = (sum > lmlt_pkg::COUNT_MAX) ? lmlt_pkg::COUNT_MAX[CW-1:0] : sum[CW-1:0];
        end
      end
      lmlt_pkg::OP_SET_EN: begin
        if (in_value_q[0] != en_q) begin
          en_d     = in_value_q[0];
          line_set = 1'b1;
          if (in_value_q[0]) begin
            cnt_d  = '0;
            st_d   = lmlt_pkg::ST_OAM;
            line_d = '0;
          end else begin
            cnt_d  = lmlt_pkg::LINE_CYCLES[CW-1:0];
            st_d   = lmlt_pkg::ST_VBLANK;
            line_d = lmlt_pkg::LAST_LINE;
          end
        end
      end
      lmlt_pkg::OP_LINE_RST: begin
        line_d   = '0;
        line_set = 1'b1;
        cnt_d    = '0;
        st_d     = lmlt_pkg::ST_OAM;
      end
      lmlt_pkg::OP_CMP_WRITE: begin
        cmp_d    = in_value_q;
        line_set = 1'b1;
      end
      default: ;
    endcase
    stat_pulse = mode_irq || (line_set && irq_en_q.coinc && (line_d == cmp_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_mode_q   <= lmlt_pkg::OP_TICK;
      in_cycles_q <= '0;
      in_value_q  <= '0;
    end else if (in_i.ready && in_i.valid) begin
      in_mode_q   <= in_i.mode;
      in_cycles_q <= in_i.cycles;
      in_value_q  <= in_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b1;
      st_q   <= lmlt_pkg::ST_OAM;
      cnt_q  <= '0;
      line_q <= '0;
      cmp_q  <= '0;
    end else if (advance) begin
      en_q   <= en_d;
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      line_q <= line_d;
      cmp_q  <= cmp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_en_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (lmlt_pkg::cfg_idx_e'(cfg_i.index))
        lmlt_pkg::CFG_HBLANK_IRQ_EN:  irq_en_q.hblank <= cfg_i.data[0];
        lmlt_pkg::CFG_VBLANK_STAT_EN: irq_en_q.vblank <= cfg_i.data[0];
        lmlt_pkg::CFG_OAM_IRQ_EN:     irq_en_q.oam    <= cfg_i.data[0];
        lmlt_pkg::CFG_COINC_IRQ_EN:   irq_en_q.coinc  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_mode_q  <= lmlt_pkg::mode_code(st_d);
      out_line_q  <= line_d;
      out_coinc_q <= (line_d == cmp_d);
      out_vbl_q   <= vbl_pulse;
      out_stat_q  <= stat_pulse;
      out_rnd_q   <= rnd_pulse;
      out_frm_q   <= frm_pulse;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.lcd_mode    = out_mode_q;
  assign out_o.line        = out_line_q;
  assign out_o.coincidence = out_coinc_q;
  assign out_o.vblank_irq  = out_vbl_q;
  assign out_o.stat_irq    = out_stat_q;
  assign out_o.render_line = out_rnd_q;
  assign out_o.frame_done  = out_frm_q;

endmodule

`default_nettype wire

/* rtl/lmlt_checker.sv */
`default_nettype none

module lmlt_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [1:0]                  lcd_mode_i,
  input wire logic [lmlt_pkg::LINE_W-1:0] line_i,
  input wire logic                        vblank_irq_i,
  input wire logic                        render_line_i,
  input wire logic                        frame_done_i
);

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> line_i <= lmlt_pkg::LAST_LINE)
    else $error("line out of range");

  // frame strobe comes only with the vblank request, on the first vblank line
  a_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (frame_done_i || vblank_irq_i) |->
      frame_done_i && vblank_irq_i && line_i == lmlt_pkg::VBLANK_FIRST_LINE &&
      lcd_mode_i == lmlt_pkg::MODE_VBLANK)
    else $error("frame strobe mismatch");

  a_render: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && render_line_i |-> lcd_mode_i == lmlt_pkg::MODE_HBLANK &&
      line_i < lmlt_pkg::VBLANK_FIRST_LINE)
    else $error("render strobe outside hblank");

  // active display modes only on visible lines
  a_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && lcd_mode_i != lmlt_pkg::MODE_VBLANK |->
      line_i < lmlt_pkg::VBLANK_FIRST_LINE)
    else $error("active mode on vblank line");

endmodule

bind lcd_mode_line_timer lmlt_checker u_lmlt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .lcd_mode_i    (out_o.lcd_mode),
  .line_i        (out_o.line),
  .vblank_irq_i  (out_o.vblank_irq),
  .render_line_i (out_o.render_line),
  .frame_done_i  (out_o.frame_done)
);

`default_nettype wire

/* sim/lcd_mode_line_timer_test.sv */
`timescale 1ns / 1ps

module lcd_mode_line_timer_test;

  localparam int FRAME_LINES = 154;

  typedef struct packed {
    lmlt_pkg::op_e op;
    logic [7:0]    cycles;
    logic [7:0]    value;
  } lcd_cmd_t;

  typedef struct packed {
    logic [1:0] lcd_mode;
    logic [7:0] line;
    logic       coincidence;
    logic       vblank_irq;
    logic       stat_irq;
    logic       render_line;
    logic       frame_done;
  } lcd_status_t;

  logic clk;
  logic rst_n;

  lmlt_in_if  cmd_if ();
  lmlt_out_if status_if ();
  lmlt_cfg_if cfg_if ();

  lcd_mode_line_timer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_if),
    .out_o  (status_if),
    .cfg_i  (cfg_if)
  );

  lcd_cmd_t    pending_cmds[$];
  lcd_status_t expected_status[$];

  // timing state as the block should hold it
  lmlt_pkg::irq_en_t irq_en;
  logic       pr_en;
  logic [1:0] pr_mode;
  int         pr_cnt;
  int         pr_line;
  logic [7:0] pr_cmp;
  logic       stat_hit;

  int errors;
  int cmds_taken;
  int results_seen;
  int frames_seen;
  int stat_seen;
  int lines_drawn;

  bit in_fire;
  int burst_left;
  int gap_left;
  lcd_cmd_t cur_cmd;

  bit hold_req;
  int hold_left;
  int pat_kind;
  int pat_left;
  int rx_cycle;

  lcd_status_t got_status;
  lcd_status_t want_status;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("lcd_mode_line_timer_test NOT OK");
    $finish;
  end

  function automatic void check_coincidence();
    if (pr_line == pr_cmp && irq_en.coinc) stat_hit = 1'b1;
  endfunction

  function automatic void move_line(int next);
    pr_line = (next >= FRAME_LINES) ? 0 : next;
    check_coincidence();
  endfunction

  function automatic void enter_mode(logic [1:0] m);
    pr_mode = m;
    if ((m == lmlt_pkg::MODE_HBLANK && irq_en.hblank) ||
        (m == lmlt_pkg::MODE_VBLANK && irq_en.vblank) ||
        (m == lmlt_pkg::MODE_OAM && irq_en.oam))
      stat_hit = 1'b1;
  endfunction

  function automatic lcd_status_t advance_timing(lmlt_pkg::op_e op, logic [7:0] cyc,
                                                 logic [7:0] val);
    lcd_status_t r;
    int sum;
    r = '0;
    stat_hit = 1'b0;
    case (op)
      lmlt_pkg::OP_TICK: begin
        if (pr_en) begin
          sum = pr_cnt + int'(cyc);
          case (pr_mode)
            lmlt_pkg::MODE_OAM: begin
              if (sum >= int'(lmlt_pkg::OAM_CYCLES)) begin
                sum -= int'(lmlt_pkg::OAM_CYCLES);
                enter_mode(lmlt_pkg::MODE_VRAM);
              end
            end
            lmlt_pkg::MODE_VRAM: begin
              if (sum >= int'(lmlt_pkg::VRAM_CYCLES)) begin
                sum -= int'(lmlt_pkg::VRAM_CYCLES);
                enter_mode(lmlt_pkg::MODE_HBLANK);
                r.render_line = 1'b1;
              end
            end
            lmlt_pkg::MODE_HBLANK: begin
              if (sum >= int'(lmlt_pkg::HBLANK_CYCLES)) begin
                sum -= int'(lmlt_pkg::HBLANK_CYCLES);
                move_line(pr_line + 1);
                if (pr_line == int'(lmlt_pkg::VBLANK_FIRST_LINE)) begin
                  enter_mode(lmlt_pkg::MODE_VBLANK);
                  r.frame_done = 1'b1;
                  r.vblank_irq = 1'b1;
                end else begin
                  enter_mode(lmlt_pkg::MODE_OAM);
                end
              end
            end
            default: begin
              if (sum >= int'(lmlt_pkg::LINE_CYCLES)) begin
                sum -= int'(lmlt_pkg::LINE_CYCLES);
                move_line(pr_line + 1);
                enter_mode((pr_line == 0) ? lmlt_pkg::MODE_OAM : lmlt_pkg::MODE_VBLANK);
              end
            end
          endcase
          pr_cnt = (sum > int'(lmlt_pkg::COUNT_MAX)) ? int'(lmlt_pkg::COUNT_MAX) : sum;
        end
      end
      lmlt_pkg::OP_SET_EN: begin
        if (val[0] != pr_en) begin
          pr_en = val[0];
          if (val[0]) begin
            pr_cnt = 0;
            pr_mode = lmlt_pkg::MODE_OAM;
            move_line(0);
          end else begin
            pr_cnt = int'(lmlt_pkg::LINE_CYCLES);
            pr_mode = lmlt_pkg::MODE_VBLANK;
            move_line(int'(lmlt_pkg::LAST_LINE));
          end
        end
      end
      lmlt_pkg::OP_LINE_RST: begin
        move_line(0);
        pr_cnt = 0;
        pr_mode = lmlt_pkg::MODE_OAM;
      end
      default: begin
        pr_cmp = val;
        check_coincidence();
      end
    endcase
    r.lcd_mode = pr_mode;
    r.line = 8'(pr_line);
    r.coincidence = (pr_line == pr_cmp);
    r.stat_irq = stat_hit;
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // command driver, bursts with random gaps
  always @(negedge clk) begin
    if (rst_n && (!cmd_if.valid || in_fire)) begin
      if (gap_left > 0 || pending_cmds.size() == 0) begin
        if (gap_left > 0) gap_left--;
        cmd_if.valid <= 1'b0;
      end else begin
        cur_cmd = pending_cmds.pop_front();
        cmd_if.valid  <= 1'b1;
        cmd_if.mode   <= cur_cmd.op;
        cmd_if.cycles <= cur_cmd.cycles;
        cmd_if.value  <= cur_cmd.value;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 50);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // status receiver, own stall pattern plus one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        status_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
        status_if.ready <= 1'b0;
      end else begin
        pat_left--;
        if (pat_left <= 0) begin
          pat_kind = $urandom_range(0, 2);
          pat_left = $urandom_range(10, 80);
        end
        case (pat_kind)
          0: status_if.ready <= 1'b1;
          1: status_if.ready <= 1'($urandom_range(0, 1));
          default: status_if.ready <= (rx_cycle % 3 != 0);
        endcase
      end
    end
  end

  // monitor: check results, then predict accepted commands
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= cmd_if.valid && cmd_if.ready;
      if (status_if.valid && status_if.ready) begin
        got_status = '{status_if.lcd_mode, status_if.line, status_if.coincidence,
                       status_if.vblank_irq, status_if.stat_irq, status_if.render_line,
                       status_if.frame_done};
        results_seen++;
        frames_seen += got_status.frame_done;
        stat_seen += got_status.stat_irq;
        lines_drawn += got_status.render_line;
        if (expected_status.size() == 0) begin
          $error("status transaction with no expectation pending");
          errors++;
        end else begin
          want_status = expected_status.pop_front();
          check_field("lcd_mode", want_status.lcd_mode, got_status.lcd_mode);
          check_field("line", want_status.line, got_status.line);
          check_field("coincidence", want_status.coincidence, got_status.coincidence);
          check_field("vblank_irq", want_status.vblank_irq, got_status.vblank_irq);
          check_field("stat_irq", want_status.stat_irq, got_status.stat_irq);
          check_field("render_line", want_status.render_line, got_status.render_line);
          check_field("frame_done", want_status.frame_done, got_status.frame_done);
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        cmds_taken++;
        expected_status.push_back(advance_timing(lmlt_pkg::op_e'(cmd_if.mode),
                                                 cmd_if.cycles, cmd_if.value));
      end
    end
  end

  task automatic queue_cmd(lmlt_pkg::op_e op, logic [7:0] cyc, logic [7:0] val);
    lcd_cmd_t c;
    c.op = op;
    c.cycles = cyc;
    c.value = val;
    pending_cmds.push_back(c);
  endtask

  task automatic write_reg(lmlt_pkg::cfg_idx_e idx, logic bit0);
    logic [7:0] d;
    d = {7'($urandom), bit0};
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      lmlt_pkg::CFG_HBLANK_IRQ_EN:  irq_en.hblank = d[0];
      lmlt_pkg::CFG_VBLANK_STAT_EN: irq_en.vblank = d[0];
      lmlt_pkg::CFG_OAM_IRQ_EN:     irq_en.oam = d[0];
      default:                      irq_en.coinc = d[0];
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic apply_config(lmlt_pkg::irq_en_t s);
    write_reg(lmlt_pkg::CFG_HBLANK_IRQ_EN, s.hblank);
    write_reg(lmlt_pkg::CFG_VBLANK_STAT_EN, s.vblank);
    write_reg(lmlt_pkg::CFG_OAM_IRQ_EN, s.oam);
    write_reg(lmlt_pkg::CFG_COINC_IRQ_EN, s.coinc);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || cmd_if.valid || expected_status.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_mixed(int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 68)
        queue_cmd(lmlt_pkg::OP_TICK, ($urandom_range(0, 4) == 0) ?
                  8'($urandom_range(0, 25)) : 8'($urandom_range(0, 255)), 8'($urandom));
      else if (pick < 78)
        queue_cmd(lmlt_pkg::OP_SET_EN, 8'($urandom), 8'($urandom));
      else if (pick < 86)
        queue_cmd(lmlt_pkg::OP_LINE_RST, 8'($urandom), 8'($urandom));
      else
        queue_cmd(lmlt_pkg::OP_CMP_WRITE, 8'($urandom), $urandom_range(0, 1) ?
                  8'($urandom_range(0, 4)) : 8'($urandom_range(0, 255)));
    end
  endtask

  // mostly ticks, so the line counter walks through a whole frame
  task automatic queue_frame_run(int n);
    int pick;
    int k;
    queue_cmd(lmlt_pkg::OP_SET_EN, 8'($urandom), {7'($urandom), 1'b1});
    repeat (n) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, 9);
      if (pick < 94)
        queue_cmd(lmlt_pkg::OP_TICK, (k < 5) ? 8'($urandom_range(20, 120)) :
                  (k < 8) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 30)),
                  8'($urandom));
      else if (pick < 98)
        queue_cmd(lmlt_pkg::OP_CMP_WRITE, 8'($urandom), 8'($urandom_range(0, 153)));
      else
        queue_cmd(lmlt_pkg::OP_SET_EN, 8'($urandom), {7'($urandom), 1'b1});
    end
  endtask

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.mode = lmlt_pkg::OP_TICK;
    cmd_if.cycles = '0;
    cmd_if.value = '0;
    status_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = lmlt_pkg::CFG_HBLANK_IRQ_EN;
    cfg_if.data = '0;
    irq_en = '0;
    pr_en = 1'b1;
    pr_mode = lmlt_pkg::MODE_OAM;
    pr_cnt = 0;
    pr_line = 0;
    pr_cmp = '0;
    burst_left = 20;
    gap_left = 0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    apply_config('{hblank: 1'b1, vblank: 1'b1, oam: 1'b1, coinc: 1'b1});
    queue_cmd(lmlt_pkg::OP_TICK, 8'd0, 8'd0);
    queue_cmd(lmlt_pkg::OP_TICK, 8'd19, 8'd255);
    queue_cmd(lmlt_pkg::OP_TICK, 8'd1, 8'd0);
    queue_cmd(lmlt_pkg::OP_TICK, 8'd42, 8'd0);
    queue_cmd(lmlt_pkg::OP_TICK, 8'd255, 8'd0);
    queue_cmd(lmlt_pkg::OP_TICK, 8'd255, 8'd0);
    queue_cmd(lmlt_pkg::OP_TICK, 8'd255, 8'd0);
    queue_cmd(lmlt_pkg::OP_TICK, 8'd255, 8'd0);
    queue_cmd(lmlt_pkg::OP_CMP_WRITE, 8'd0, 8'd2);
    queue_cmd(lmlt_pkg::OP_TICK, 8'd255, 8'd0);
    queue_cmd(lmlt_pkg::OP_CMP_WRITE, 8'd255, 8'd255);
    queue_cmd(lmlt_pkg::OP_SET_EN, 8'd0, 8'hFE);
    queue_cmd(lmlt_pkg::OP_TICK, 8'd255, 8'd0);
    queue_cmd(lmlt_pkg::OP_SET_EN, 8'd0, 8'hFE);
    queue_cmd(lmlt_pkg::OP_LINE_RST, 8'd255, 8'd255);
    queue_cmd(lmlt_pkg::OP_CMP_WRITE, 8'd0, 8'd0);
    queue_cmd(lmlt_pkg::OP_TICK, 8'd100, 8'd0);
    queue_cmd(lmlt_pkg::OP_SET_EN, 8'd0, 8'h01);
    queue_cmd(lmlt_pkg::OP_SET_EN, 8'd0, 8'hFF);
    queue_cmd(lmlt_pkg::OP_TICK, 8'd200, 8'd0);
    queue_cmd(lmlt_pkg::OP_LINE_RST, 8'd0, 8'd0);
    queue_cmd(lmlt_pkg::OP_CMP_WRITE, 8'd0, 8'd153);
    queue_cmd(lmlt_pkg::OP_SET_EN, 8'd0, 8'h00);
    queue_cmd(lmlt_pkg::OP_SET_EN, 8'd0, 8'h01);
    drain();

    apply_config('{hblank: 1'b0, vblank: 1'b0, oam: 1'b0, coinc: 1'b0});
    queue_mixed(40);
    @(posedge clk);
    hold_req = 1'b1;
    drain();

    apply_config('{hblank: 1'b0, vblank: 1'b1, oam: 1'b0, coinc: 1'b1});
    queue_frame_run(270);
    drain();

    apply_config('{hblank: 1'b1, vblank: 1'b1, oam: 1'b1, coinc: 1'b1});
    queue_frame_run(270);
    drain();

    apply_config(lmlt_pkg::irq_en_t'(4'($urandom_range(0, 15))));
    queue_mixed(20);
    drain();

    apply_config('{hblank: 1'b1, vblank: 1'b0, oam: 1'b1, coinc: 1'b0});
    queue_mixed(20);
    drain();

    $display("%0d commands checked against %0d status transactions", cmds_taken,
             results_seen);
    $display("%0d frames, %0d stat requests, %0d rendered lines seen", frames_seen,
             stat_seen, lines_drawn);
    if (errors == 0) begin
      $display("lcd_mode_line_timer_test OK");
    end else begin
      $display("lcd_mode_line_timer_test NOT OK");
    end
    $finish;
  end

endmodule
